// ----- hw/rtl/causal_complex_fir_filter_unit_defines.svh -----
// Assertion macros for the filter RTL.
`ifndef CAUSAL_COMPLEX_FIR_FILTER_UNIT_DEFINES_SVH
`define CAUSAL_COMPLEX_FIR_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define CFIR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every rising edge, reset included.
`define CFIR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CFIR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CFIR_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- hw/rtl/cfir_pkg.sv -----
package cfir_pkg;

    localparam int MAX_TAPS_DEFAULT    = 64;
    localparam int SAMPLE_BITS_DEFAULT = 16;

    // Fixed field widths of the item format.
    localparam int TAP_BITS      = 6;
    localparam int TAPS_CNT_BITS = 7;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int ACC_BITS      = 64;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAPS_IN_USE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_COMPLEX_MODE = 2'd1;

    // Command codes carried in tuser bit 0.
    localparam logic CMD_SAMPLE   = 1'b0;
    localparam logic CMD_LOAD_TAP = 1'b1;

    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    // Partial sums handed from one cell to the next.
    typedef struct packed {
        logic                       valid;
        logic signed [ACC_BITS-1:0] acc_r;
        logic signed [ACC_BITS-1:0] acc_i;
    } wave_t;

    // Controls broadcast to every cell.
    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
        logic cplx;
    } cell_ctrl_t;

    // Status of the rounding and output stage.
    typedef struct packed {
        logic moved;
        logic pend_valid;
    } rnd_status_t;

    // Add that clips at the accumulator limits instead of wrapping.
    function automatic logic signed [ACC_BITS-1:0] sat_add(
        input logic signed [ACC_BITS-1:0] a,
        input logic signed [ACC_BITS-1:0] b
    );
        logic signed [ACC_BITS-1:0] s;
        s = a + b;
        if ((a[ACC_BITS-1] == b[ACC_BITS-1]) && (s[ACC_BITS-1] != a[ACC_BITS-1]))
        begin
            s = a[ACC_BITS-1] ? ACC_MIN : ACC_MAX;
        end
        return s;
    endfunction

endpackage

// ----- hw/rtl/cfir_cell.sv -----
module cfir_cell #(
    parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS_DEFAULT,
    parameter int INDEX       = 0
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cfir_pkg::cell_ctrl_t                 ctrl,
    input  logic [cfir_pkg::TAPS_CNT_BITS-1:0]   taps,
    input  logic [cfir_pkg::TAP_BITS-1:0]        tap_index,
    input  logic signed [SAMPLE_BITS-1:0]        din_re,
    input  logic signed [SAMPLE_BITS-1:0]        din_im,
    input  logic signed [SAMPLE_BITS-1:0]        coef_in_re,
    input  logic signed [SAMPLE_BITS-1:0]        coef_in_im,
    output logic signed [SAMPLE_BITS-1:0]        hist_re,
    output logic signed [SAMPLE_BITS-1:0]        hist_im,
    input  cfir_pkg::wave_t                      wave_in,
    output cfir_pkg::wave_t                      wave_out
);

    localparam int PB = 2 * SAMPLE_BITS;

    logic signed [SAMPLE_BITS-1:0]        hist_re_reg, hist_im_reg;
    logic signed [SAMPLE_BITS-1:0]        coef_re_reg, coef_im_reg;
    logic signed [PB-1:0]                 p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic                                 valid_reg;
    logic signed [cfir_pkg::ACC_BITS-1:0] acc_r_reg, acc_i_reg;
    logic signed [cfir_pkg::ACC_BITS-1:0] acc_r_next, acc_i_next;
    logic                                 en;

    assign en = (int'(taps) > INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_re_reg <= '0;
            hist_im_reg <= '0;
            coef_re_reg <= '0;
            coef_im_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.shift)
            begin
                // A vector start empties every older slot.
                if (ctrl.clear && (INDEX != 0))
                begin
                    hist_re_reg <= '0;
                    hist_im_reg <= '0;
                end
                else
                begin
                    hist_re_reg <= din_re;
                    hist_im_reg <= din_im;
                end
            end
            if (ctrl.load && (int'(tap_index) == INDEX))
            begin
                coef_re_reg <= coef_in_re;
                coef_im_reg <= coef_in_im;
            end
            valid_reg <= wave_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rr_reg  <= coef_re_reg * hist_re_reg;
        p_ii_reg  <= coef_im_reg * hist_im_reg;
        p_ri_reg  <= coef_re_reg * hist_im_reg;
        p_ir_reg  <= coef_im_reg * hist_re_reg;
        acc_r_reg <= acc_r_next;
        acc_i_reg <= acc_i_next;
    end

    always_comb
    begin
        acc_r_next = wave_in.acc_r;
        acc_i_next = wave_in.acc_i;
        if (en)
        begin
            acc_r_next = cfir_pkg::sat_add(acc_r_next, cfir_pkg::ACC_BITS'(p_rr_reg));
            if (ctrl.cplx)
            begin
                acc_r_next = cfir_pkg::sat_add(acc_r_next,
                                               -cfir_pkg::ACC_BITS'(p_ii_reg));
                acc_i_next = cfir_pkg::sat_add(acc_i_next, cfir_pkg::ACC_BITS'(p_ri_reg));
                acc_i_next = cfir_pkg::sat_add(acc_i_next, cfir_pkg::ACC_BITS'(p_ir_reg));
            end
        end
    end

    assign hist_re        = hist_re_reg;
    assign hist_im        = hist_im_reg;
    assign wave_out.valid = valid_reg;
    assign wave_out.acc_r = acc_r_reg;
    assign wave_out.acc_i = acc_i_reg;

endmodule

// ----- hw/rtl/cfir_round.sv -----
module cfir_round #(
    parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfir_pkg::wave_t               wave_in,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic signed [SAMPLE_BITS-1:0] out_re,
    output logic signed [SAMPLE_BITS-1:0] out_im,
    output logic                          out_sat,
    output cfir_pkg::rnd_status_t         status
);

    localparam int AB = cfir_pkg::ACC_BITS;
    localparam logic signed [AB-1:0] HALF = AB'(1) << (SAMPLE_BITS - 2);

    // Round half up to the sample format, then clip. Bit SAMPLE_BITS is the clip flag.
    function automatic logic [SAMPLE_BITS:0] finish(input logic signed [AB-1:0] acc);
        logic signed [AB-1:0]    v;
        logic [AB-SAMPLE_BITS:0] top;
        logic [SAMPLE_BITS:0]    r;
        v   = cfir_pkg::sat_add(acc, HALF);
        v   = v >>> (SAMPLE_BITS - 1);
        top = v[AB-1:SAMPLE_BITS-1];
        if ((&top) || !(|top))
        begin
            r = {1'b0, v[SAMPLE_BITS-1:0]};
        end
        else if (v[AB-1])
        begin
            r = {1'b1, 1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b1, 1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
        return r;
    endfunction

    logic [SAMPLE_BITS:0]          fin_re, fin_im;
    logic                          pend_valid_reg;
    logic signed [SAMPLE_BITS-1:0] pend_re_reg, pend_im_reg;
    logic                          pend_sat_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_re_reg, out_im_reg;
    logic                          out_sat_reg;
    logic                          moved;

    assign fin_re = finish(wave_in.acc_r);
    assign fin_im = finish(wave_in.acc_i);
    assign moved  = pend_valid_reg && (!out_valid_reg || m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wave_in.valid)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (moved)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (moved)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wave_in.valid)
        begin
            pend_re_reg  <= fin_re[SAMPLE_BITS-1:0];
            pend_im_reg  <= fin_im[SAMPLE_BITS-1:0];
            pend_sat_reg <= fin_re[SAMPLE_BITS] | fin_im[SAMPLE_BITS];
        end
        if (moved)
        begin
            out_re_reg  <= pend_re_reg;
            out_im_reg  <= pend_im_reg;
            out_sat_reg <= pend_sat_reg;
        end
    end

    assign m_axis_tvalid     = out_valid_reg;
    assign out_re            = out_re_reg;
    assign out_im            = out_im_reg;
    assign out_sat           = out_sat_reg;
    assign status.moved      = moved;
    assign status.pend_valid = pend_valid_reg;

endmodule

// ----- hw/rtl/causal_complex_fir_filter_unit.sv -----
// Causal direct-form FIR filter for Q1.15 samples, real or complex. Each sample
// transaction (tuser bit 0 low) yields one output transaction carrying the rounded
// and saturated sum of coefficient times history over the first taps_in_use taps;
// a tap transaction (tuser bit 0 high) writes one coefficient. Setting tuser bit 1
// on a sample starts a new vector with an empty history. The filter is a row of
// MAX_TAPS cells, one tap each: the new sample shifts into the history row, then a
// partial sum travels the row one cell per cycle. No transaction is taken while
// a sample is in flight, until its result has moved into the output register. A
// finished result may wait in the output register while the next sample is
// already being processed.
`include "causal_complex_fir_filter_unit_defines.svh"

module causal_complex_fir_filter_unit #(
    parameter int MAX_TAPS    = cfir_pkg::MAX_TAPS_DEFAULT,
    parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS_DEFAULT,
    localparam int IN_BITS    = ((cfir_pkg::TAP_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_BITS   = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata from bit 0: tap_index (6), real_part, imag_part, zero fill.
    input  logic [IN_BITS-1:0]                 s_axis_tdata,
    // tuser from bit 0: cmd, first.
    input  logic [1:0]                         s_axis_tuser,
    // Output stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata from bit 0: out_real, out_imag, zero fill.
    output logic [OUT_BITS-1:0]                m_axis_tdata,
    // tuser from bit 0: saturated.
    output logic [0:0]                         m_axis_tuser,
    // Configuration writes.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cfir_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [cfir_pkg::CFG_DATA_BITS-1:0] cfg_data
);

    logic                                 busy_reg;
    logic                                 launch_reg, launch2_reg;
    logic [cfir_pkg::TAPS_CNT_BITS-1:0]   taps_reg;
    logic                                 cplx_reg;
    logic                                 in_xact, sample_xact, load_xact;
    logic [cfir_pkg::TAP_BITS-1:0]        in_tap;
    logic signed [SAMPLE_BITS-1:0]        in_re, in_im;
    cfir_pkg::cell_ctrl_t                 ctrl;
    cfir_pkg::wave_t                      chain [MAX_TAPS+1];
    logic [MAX_TAPS:0]                    chain_valid;
    logic signed [SAMPLE_BITS-1:0]        hist_re [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]        hist_im [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0]        out_re, out_im;
    logic                                 out_sat;
    cfir_pkg::rnd_status_t                rnd_status;

    // Field unpacking of the input transaction.
    assign in_tap = s_axis_tdata[cfir_pkg::TAP_BITS-1:0];
    assign in_re  = s_axis_tdata[cfir_pkg::TAP_BITS +: SAMPLE_BITS];
    assign in_im  = s_axis_tdata[cfir_pkg::TAP_BITS + SAMPLE_BITS +: SAMPLE_BITS];

    // One item is in flight from sample acceptance until its result reaches the
    // output register; tap loads are also held off so coefficients stay still.
    assign s_axis_tready = !busy_reg;
    assign in_xact       = s_axis_tvalid && s_axis_tready;
    assign sample_xact   = in_xact && (s_axis_tuser[0] == cfir_pkg::CMD_SAMPLE);
    assign load_xact     = in_xact && (s_axis_tuser[0] == cfir_pkg::CMD_LOAD_TAP);

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            launch_reg  <= 1'b0;
            launch2_reg <= 1'b0;
            taps_reg    <= cfir_pkg::TAPS_CNT_BITS'(1);
            cplx_reg    <= 1'b0;
        end
        else
        begin
            if (sample_xact)
            begin
                busy_reg <= 1'b1;
            end
            else if (rnd_status.moved)
            begin
                busy_reg <= 1'b0;
            end
            // The extra stage lets every cell register its products from the
            // freshly shifted history before the partial sum arrives.
            launch_reg  <= sample_xact;
            launch2_reg <= launch_reg;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    cfir_pkg::CFG_TAPS_IN_USE:  taps_reg <= cfg_data;
                    cfir_pkg::CFG_COMPLEX_MODE: cplx_reg <= cfg_data[0];
                    default:                    ;
                endcase
            end
        end
    end

    assign ctrl.shift = sample_xact;
    assign ctrl.clear = s_axis_tuser[1];
    assign ctrl.load  = load_xact;
    assign ctrl.cplx  = cplx_reg;

    // A fresh partial sum of zero enters the first cell.
    assign chain[0].valid = launch2_reg;
    assign chain[0].acc_r = '0;
    assign chain[0].acc_i = '0;

    genvar k;
    generate
        for (k = 0; k <= MAX_TAPS; k++)
        begin : g_valid
            assign chain_valid[k] = chain[k].valid;
        end
        for (k = 0; k < MAX_TAPS; k++)
        begin : g_cell
            logic signed [SAMPLE_BITS-1:0] din_re, din_im;
            if (k == 0)
            begin : g_head
                assign din_re = in_re;
                assign din_im = in_im;
            end
            else
            begin : g_body
                assign din_re = hist_re[k-1];
                assign din_im = hist_im[k-1];
            end
            cfir_cell #(
                .SAMPLE_BITS(SAMPLE_BITS),
                .INDEX      (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .taps      (taps_reg),
                .tap_index (in_tap),
                .din_re    (din_re),
                .din_im    (din_im),
                .coef_in_re(in_re),
                .coef_in_im(in_im),
                .hist_re   (hist_re[k]),
                .hist_im   (hist_im[k]),
                .wave_in   (chain[k]),
                .wave_out  (chain[k+1])
            );
        end
    endgenerate

    cfir_round #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_round (
        .clk          (clk),
        .rst_n        (rst_n),
        .wave_in      (chain[MAX_TAPS]),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .out_re       (out_re),
        .out_im       (out_im),
        .out_sat      (out_sat),
        .status       (rnd_status)
    );

    assign m_axis_tdata    = OUT_BITS'({out_im, out_re});
    assign m_axis_tuser[0] = out_sat;

    // Only one partial sum may travel the row at a time.
    `CFIR_ASSERT(a_one_wave, clk, rst_n, $countones(chain_valid) <= 1, "two partial sums in the row")
    // A sum leaving the row belongs to the sample still marked in flight.
    `CFIR_ASSERT(a_exit_busy, clk, rst_n, chain[MAX_TAPS].valid |-> busy_reg, "sum left the row while idle")
    // A finished sum never overwrites one still waiting for the output register.
    `CFIR_ASSERT(a_no_overwrite, clk, rst_n, chain[MAX_TAPS].valid |-> !rnd_status.pend_valid, "pending result overwritten")
    // Nothing is launched or shown in the cycle after reset was seen low.
    `CFIR_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> (!m_axis_tvalid && !launch_reg), "activity during reset")

endmodule

// ----- dv/causal_complex_fir_filter_unit_tb.sv -----
`timescale 1ns / 1ps

// Self-checking testbench for the causal FIR filter unit.
//
// A queue of pending input transactions is filled by the main initial block,
// one filter setting at a time. A clocked driver presents those transactions on
// the input stream at the falling edge. A clocked monitor samples both streams
// at the rising edge. Every accepted input transaction goes through a local
// fixed-point filter model, and each sample leaves one expected output behind.
// Each output transaction is checked field by field against the oldest
// expectation. Configuration is only changed while the filter is idle.
module causal_complex_fir_filter_unit_tb;

    localparam int TAP_BITS      = cfir_pkg::TAP_BITS;
    localparam int TAPS_CNT_BITS = cfir_pkg::TAPS_CNT_BITS;
    localparam int CFG_IDX_BITS  = cfir_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = cfir_pkg::CFG_DATA_BITS;

    localparam int FIR_TAPS = cfir_pkg::MAX_TAPS_DEFAULT;
    localparam int SB       = cfir_pkg::SAMPLE_BITS_DEFAULT;
    localparam int IN_W     = ((TAP_BITS + 2 * SB + 7) / 8) * 8;
    localparam int OUT_W    = ((2 * SB + 7) / 8) * 8;

    // This margin covers a transaction that is still in flight after the last
    // expected output.
    localparam int DRAIN_CYCLES = FIR_TAPS + 12;
    // Long output hold-off, so that the input side backs up.
    localparam int HOLD_CYCLES  = 6 * (FIR_TAPS + 4);

    // Register indexes that map to no register; writes to them must change nothing.
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [SB-1:0] Q15_MAX  = 16'h7FFF;
    localparam logic [SB-1:0] Q15_MIN  = 16'h8000;
    localparam logic [SB-1:0] Q15_HALF = 16'h4000;
    localparam logic [SB-1:0] Q15_ONE  = 16'h0001;
    localparam logic [SB-1:0] Q15_NEG1 = 16'hFFFF;

    typedef struct {
        logic                cmd;
        logic                first;
        logic [TAP_BITS-1:0] idx;
        logic [SB-1:0]       re;
        logic [SB-1:0]       im;
    } fir_item_t;

    typedef struct packed {
        logic signed [SB-1:0] out_re;
        logic signed [SB-1:0] out_im;
        logic                 sat;
    } fir_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // tdata from bit 0: tap_index (6), real_part (16), imag_part (16), zero fill.
    logic [IN_W-1:0]          s_axis_tdata = '0;
    // tuser from bit 0: cmd, first.
    logic [1:0]               s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // tdata from bit 0: out_real (16), out_imag (16).
    logic [OUT_W-1:0]         m_axis_tdata;
    // tuser from bit 0: saturated.
    logic [0:0]               m_axis_tuser;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    // Local copy of the filter state and its settings.
    logic signed [SB-1:0]      hist_re [FIR_TAPS];
    logic signed [SB-1:0]      hist_im [FIR_TAPS];
    logic signed [SB-1:0]      coef_re [FIR_TAPS];
    logic signed [SB-1:0]      coef_im [FIR_TAPS];
    logic [TAPS_CNT_BITS-1:0]  taps_cfg = 7'd1;
    logic                      cplx_cfg = 1'b0;

    fir_item_t   pending_items[$];
    fir_result_t filter_outputs_due[$];

    fir_item_t   drv_item;
    fir_result_t want;
    logic        in_fire = 1'b0;
    logic        hold_active = 1'b0;
    event        hold_kick;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    int mismatches = 0;
    int samples_done = 0;
    int loads_done = 0;
    int clipped_seen = 0;
    int settings_run = 0;

    causal_complex_fir_filter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Round half toward plus infinity from Q2.30 to Q1.15, then clip.
    function automatic logic signed [SB-1:0] q15_round(input longint acc, inout bit clip);
        longint v;
        v = (acc + (longint'(1) <<< (SB - 2))) >>> (SB - 1);
        if (v > 32767)
        begin
            v = 32767;
            clip = 1'b1;
        end
        if (v < -32768)
        begin
            v = -32768;
            clip = 1'b1;
        end
        return v[SB-1:0];
    endfunction

    // Applies one accepted input transaction to the local filter state. A tap load
    // only writes the coefficient store; a sample shifts the history and leaves one
    // expected output. With 16-bit operands the 64-bit sum can never overflow, so
    // plain addition matches the saturating accumulator.
    function automatic void fir_take_item(
        input logic                 cmd,
        input logic                 first,
        input logic [TAP_BITS-1:0]  idx,
        input logic signed [SB-1:0] re,
        input logic signed [SB-1:0] im
    );
        int          n_taps;
        longint      acc_r;
        longint      acc_i;
        bit          clip;
        fir_result_t res;
        if (cmd == cfir_pkg::CMD_LOAD_TAP)
        begin
            coef_re[idx] = re;
            coef_im[idx] = im;
            return;
        end
        if (first)
        begin
            for (int k = 0; k < FIR_TAPS; k++)
            begin
                hist_re[k] = '0;
                hist_im[k] = '0;
            end
        end
        for (int k = FIR_TAPS - 1; k > 0; k--)
        begin
            hist_re[k] = hist_re[k-1];
            hist_im[k] = hist_im[k-1];
        end
        hist_re[0] = re;
        hist_im[0] = im;
        n_taps = (taps_cfg > FIR_TAPS) ? FIR_TAPS : int'(taps_cfg);
        acc_r = 0;
        acc_i = 0;
        for (int k = 0; k < n_taps; k++)
        begin
            acc_r += longint'(coef_re[k]) * longint'(hist_re[k]);
            if (cplx_cfg)
            begin
                acc_r -= longint'(coef_im[k]) * longint'(hist_im[k]);
                acc_i += longint'(coef_re[k]) * longint'(hist_im[k]);
                acc_i += longint'(coef_im[k]) * longint'(hist_re[k]);
            end
        end
        clip = 1'b0;
        res.out_re = q15_round(acc_r, clip);
        res.out_im = cplx_cfg ? q15_round(acc_i, clip) : '0;
        res.sat    = clip;
        filter_outputs_due.push_back(res);
    endfunction

    // Driver: a new transaction is offered once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_fire))
        begin
            if (pending_items.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                drv_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {{(IN_W - TAP_BITS - 2 * SB){1'b0}},
                                  drv_item.im, drv_item.re, drv_item.idx};
                s_axis_tuser  <= {drv_item.first, drv_item.cmd};
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Output side: random stalls, or a solid hold-off while one is running.
    always @(negedge clk)
    begin
        if (hold_active)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always
    begin
        @(hold_kick);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active = 1'b0;
    end

    // Monitor: both handshakes are evaluated on the values before the edge.
    always @(posedge clk)
    begin
        in_fire = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_fire)
        begin
            fir_take_item(s_axis_tuser[0], s_axis_tuser[1], s_axis_tdata[TAP_BITS-1:0],
                          s_axis_tdata[TAP_BITS+SB-1:TAP_BITS],
                          s_axis_tdata[TAP_BITS+2*SB-1:TAP_BITS+SB]);
            if (s_axis_tuser[0] == cfir_pkg::CMD_LOAD_TAP)
                loads_done++;
            else
                samples_done++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (filter_outputs_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output with no sample pending: re=%0d im=%0d sat=%0b",
                             $time, $signed(m_axis_tdata[SB-1:0]),
                             $signed(m_axis_tdata[2*SB-1:SB]), m_axis_tuser[0]);
            end
            else
            begin
                want = filter_outputs_due.pop_front();
                if (want.sat)
                    clipped_seen++;
                if (m_axis_tdata[SB-1:0] !== want.out_re ||
                    m_axis_tdata[2*SB-1:SB] !== want.out_im ||
                    m_axis_tuser[0] !== want.sat)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: output mismatch: expected re=%0d im=%0d sat=%0b,",
                                  " got re=%0d im=%0d sat=%0b"},
                                 $time, want.out_re, want.out_im, want.sat,
                                 $signed(m_axis_tdata[SB-1:0]),
                                 $signed(m_axis_tdata[2*SB-1:SB]), m_axis_tuser[0]);
                end
            end
        end
    end

    function automatic void push_item(
        input logic                cmd,
        input logic                first,
        input logic [TAP_BITS-1:0] idx,
        input logic [SB-1:0]       re,
        input logic [SB-1:0]       im
    );
        fir_item_t it;
        it.cmd   = cmd;
        it.first = first;
        it.idx   = idx;
        it.re    = re;
        it.im    = im;
        pending_items.push_back(it);
    endfunction

    // Full-scale values show up often so that clipping is reached regularly.
    function automatic logic [SB-1:0] q15_pick();
        case ($urandom_range(7))
            0:       return Q15_MAX;
            1:       return Q15_MIN;
            2:       return '0;
            default: return SB'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // Mostly taps inside the active span, sometimes anywhere in the store.
    function automatic logic [TAP_BITS-1:0] pick_tap(input int span);
        if ($urandom_range(3) == 0)
            return TAP_BITS'($urandom_range(FIR_TAPS - 1));
        return TAP_BITS'($urandom_range(span - 1));
    endfunction

    // Queues coefficient loads followed by a vector of samples, repeatedly. Most
    // vectors open with a start mark; a few do not, and a few restart midway.
    task automatic queue_vectors(input int n_items, input int taps);
        int span;
        int pushed;
        int n_loads;
        int vec_len;
        span   = (taps < 1) ? 1 : ((taps > FIR_TAPS) ? FIR_TAPS : taps);
        pushed = 0;
        while (pushed < n_items)
        begin
            n_loads = $urandom_range(1, 6);
            for (int k = 0; k < n_loads && pushed < n_items; k++)
            begin
                push_item(cfir_pkg::CMD_LOAD_TAP, 1'($urandom_range(1)), pick_tap(span),
                          q15_pick(), q15_pick());
                pushed++;
            end
            vec_len = $urandom_range(4, 40);
            for (int k = 0; k < vec_len && pushed < n_items; k++)
            begin
                if ($urandom_range(19) == 0)
                    push_item(cfir_pkg::CMD_LOAD_TAP, 1'($urandom_range(1)), pick_tap(span),
                              q15_pick(), q15_pick());
                else
                    push_item(cfir_pkg::CMD_SAMPLE,
                              (k == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0),
                              TAP_BITS'($urandom_range(FIR_TAPS - 1)), q15_pick(), q15_pick());
                pushed++;
            end
        end
    endtask

    // Waits until every queued transaction went in and every output came out,
    // then gives a trailing tap load time to settle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || s_axis_tvalid || filter_outputs_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            cfir_pkg::CFG_TAPS_IN_USE:  taps_cfg = val;
            cfir_pkg::CFG_COMPLEX_MODE: cplx_cfg = val[0];
            default:                    ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One filter setting: settle, program both registers, then stream a batch.
    // The upper bits of the mode write are junk and must be ignored.
    task automatic run_setting(input logic [TAPS_CNT_BITS-1:0] taps, input logic cplx,
                               input int src_pct, input int sink_pct, input int n_items,
                               input bit with_hold);
        logic [CFG_DATA_BITS-2:0] junk;
        wait_idle();
        junk = (CFG_DATA_BITS - 1)'($urandom_range(63));
        write_reg(cfir_pkg::CFG_TAPS_IN_USE, taps);
        write_reg(cfir_pkg::CFG_COMPLEX_MODE, {junk, cplx});
        settings_run++;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        queue_vectors(n_items, int'(taps));
        if (with_hold)
            -> hold_kick;
    endtask

    initial
    begin
        for (int k = 0; k < FIR_TAPS; k++)
        begin
            hist_re[k] = '0;
            hist_im[k] = '0;
            coef_re[k] = '0;
            coef_im[k] = '0;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part: four complex taps with full-scale and half-scale values,
        // a store write above the active span, and the rounding ties on both
        // signs. A start mark on a tap load must be ignored.
        write_reg(cfir_pkg::CFG_TAPS_IN_USE, 7'd4);
        write_reg(cfir_pkg::CFG_COMPLEX_MODE, 7'd1);
        settings_run++;
        push_item(cfir_pkg::CMD_LOAD_TAP, 1'b1, 6'd0,  Q15_HALF, '0);
        push_item(cfir_pkg::CMD_LOAD_TAP, 1'b0, 6'd1,  Q15_MAX,  Q15_MIN);
        push_item(cfir_pkg::CMD_LOAD_TAP, 1'b0, 6'd2,  Q15_MIN,  Q15_MIN);
        push_item(cfir_pkg::CMD_LOAD_TAP, 1'b0, 6'd3,  '0,       Q15_MAX);
        push_item(cfir_pkg::CMD_LOAD_TAP, 1'b1, 6'd63, Q15_MAX,  Q15_MAX);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b1, 6'd0,  Q15_ONE,  '0);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b1, 6'd0,  Q15_NEG1, '0);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b1, 6'd63, Q15_MIN,  Q15_MIN);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b0, 6'd0,  Q15_MAX,  Q15_MAX);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b0, 6'd0,  Q15_MIN,  '0);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b0, 6'd0,  '0,       Q15_MIN);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b0, 6'd0,  Q15_MAX,  Q15_MIN);
        push_item(cfir_pkg::CMD_LOAD_TAP, 1'b0, 6'd2,  Q15_MIN,  '0);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b0, 6'd0,  Q15_MIN,  Q15_MIN);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b0, 6'd0,  Q15_MIN,  Q15_MIN);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b1, 6'd0,  Q15_MAX,  Q15_MAX);
        push_item(cfir_pkg::CMD_LOAD_TAP, 1'b0, 6'd0,  Q15_MIN,  Q15_MIN);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b1, 6'd0,  Q15_MIN,  Q15_MIN);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b0, 6'd0,  Q15_MIN,  Q15_MAX);
        push_item(cfir_pkg::CMD_SAMPLE,   1'b0, 6'd0,  '0,       '0);

        // A tap count of zero must give silent outputs; the unmapped indexes
        // are written here too.
        wait_idle();
        write_reg(CFG_SPARE_A, CFG_DATA_BITS'($urandom_range(127)));
        write_reg(CFG_SPARE_B, CFG_DATA_BITS'($urandom_range(127)));
        run_setting(7'd0, 1'b1, 12, 12, 30, 1'b0);

        // Random part over several settings and idle patterns. The first one
        // holds the output off for a long stretch while samples keep coming.
        run_setting(7'd64,  1'b1,  0,  0, 125, 1'b1);
        run_setting(7'd1,   1'b0, 65,  0, 125, 1'b0);
        run_setting(7'd127, 1'b1,  0, 65, 125, 1'b0);
        run_setting(TAPS_CNT_BITS'($urandom_range(1, 64)), 1'b0, 12, 12, 125, 1'b0);
        run_setting(7'd100, 1'b0,  0,  0, 125, 1'b0);
        run_setting(7'd2,   1'b1, 65,  0, 125, 1'b0);
        run_setting(TAPS_CNT_BITS'($urandom_range(127)), 1'($urandom_range(1)),
                    0, 65, 125, 1'b0);
        run_setting(7'd33,  1'b1, 12, 12, 125, 1'b0);
        wait_idle();

        $display("Covered %0d samples and %0d coefficient loads over %0d filter settings,",
                 samples_done, loads_done, settings_run);
        $display("tap counts 0 to 127 in real and complex mode, %0d clipped outputs.",
                 clipped_seen);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Far beyond the slowest correct run.
    initial
    begin
        #(10_000_000);
        $display("Timeout: %0d input transactions and %0d outputs still outstanding.",
                 pending_items.size(), filter_outputs_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- causal_complex_fir_filter_unit.f -----
+incdir+hw/rtl
hw/rtl/cfir_pkg.sv
hw/rtl/cfir_cell.sv
hw/rtl/cfir_round.sv
hw/rtl/causal_complex_fir_filter_unit.sv
dv/causal_complex_fir_filter_unit_tb.sv
